@@ rtl/cmfs_pkg.sv @@
`timescale 1ns / 1ps

package cmfs_pkg;

  // Component and coordinate widths
  localparam int COMP_WIDTH  = 16;
  localparam int COORD_WIDTH = 16;

  // Width of divider numerator, denominator and remainder (holds 2 * max magnitude)
  localparam int DIV_WIDTH = COMP_WIDTH + 1;

  // Request to result: three front stages, one stage per quotient bit, output register
  localparam int LATENCY = COORD_WIDTH + 4;

  // Face codes
  localparam logic [2:0] FACE_POS_X = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_Y = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_POS_Z = 3'd4;
  localparam logic [2:0] FACE_NEG_Z = 3'd5;

  // Payload of one divider stage; both coordinates share the denominator
  typedef struct packed {
    logic [2:0]             face;
    logic                   zero;
    logic                   sat_u;
    logic                   sat_v;
    logic [DIV_WIDTH-1:0]   den;
    logic [DIV_WIDTH-1:0]   rem_u;
    logic [DIV_WIDTH-1:0]   rem_v;
    logic [COORD_WIDTH-1:0] quot_u;
    logic [COORD_WIDTH-1:0] quot_v;
  } div_stage_t;

endpackage

@@ rtl/cube_map_face_select.sv @@
`timescale 1ns / 1ps

// Cube map face select.
// Input channel: a request (in_dir_x, in_dir_y, in_dir_z, signed fixed point)
// is taken at a rising edge where start is high and busy is low. busy stays
// low, so a new request may be issued every clock cycle.
// Result channel: out_valid is high for exactly one cycle with out_face,
// out_coord_u, out_coord_v and out_zero_vector; the receiver takes it at the
// edge that ends that cycle and cannot hold it off.
// Throughput: one request per clock. Three front stages take the magnitudes,
// pick the face and form numerator and denominator; the restoring divider
// then resolves one quotient bit of u and v per pipeline stage, and an output
// register presents the result.
// Coordinates are floor((s + ma) * 2^COORD_WIDTH / (2 * ma)), with an exact
// 1.0 saturated to all ones. An all-zero vector reports face -Z, u = v = 0
// and raises out_zero_vector.
// Reset (rst_n low, synchronous) clears all stage valid bits, so requests in
// flight are dropped and no result appears until new requests arrive.
module cube_map_face_select (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [cmfs_pkg::COMP_WIDTH-1:0] in_dir_x,
  input  logic signed [cmfs_pkg::COMP_WIDTH-1:0] in_dir_y,
  input  logic signed [cmfs_pkg::COMP_WIDTH-1:0] in_dir_z,
  output logic                                 out_valid,
  output logic [2:0]                           out_face,
  output logic [cmfs_pkg::COORD_WIDTH-1:0]     out_coord_u,
  output logic [cmfs_pkg::COORD_WIDTH-1:0]     out_coord_v,
  output logic                                 out_zero_vector
);

  localparam int CW = cmfs_pkg::COMP_WIDTH;
  localparam int QW = cmfs_pkg::COORD_WIDTH;
  localparam int DW = cmfs_pkg::DIV_WIDTH;

  // Pipeline never stalls
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage 1: magnitudes and signs
  // ---------------------------------------------------------------------------
  logic                 s1_valid_r;
  logic signed [CW-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic [CW-1:0]        s1_ax_r, s1_ay_r, s1_az_r;
  logic                 s1_px_r, s1_py_r, s1_pz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_x_r  <= in_dir_x;
    s1_y_r  <= in_dir_y;
    s1_z_r  <= in_dir_z;
    s1_ax_r <= in_dir_x[CW-1] ? (~in_dir_x + 1'b1) : in_dir_x;
    s1_ay_r <= in_dir_y[CW-1] ? (~in_dir_y + 1'b1) : in_dir_y;
    s1_az_r <= in_dir_z[CW-1] ? (~in_dir_z + 1'b1) : in_dir_z;
    s1_px_r <= ~in_dir_x[CW-1] & (|in_dir_x);
    s1_py_r <= ~in_dir_y[CW-1] & (|in_dir_y);
    s1_pz_r <= ~in_dir_z[CW-1] & (|in_dir_z);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: pick the major axis, face and signed s, t
  // ---------------------------------------------------------------------------
  logic                 s2_valid_r;
  logic [2:0]           s2_face_r,  s2_face_nxt;
  logic [CW-1:0]        s2_ma_r,    s2_ma_nxt;
  logic signed [DW-1:0] s2_s_r,     s2_s_nxt;
  logic signed [DW-1:0] s2_t_r,     s2_t_nxt;

  logic signed [DW-1:0] ext_x, ext_y, ext_z;

  always_comb begin
    ext_x = {s1_x_r[CW-1], s1_x_r};
    ext_y = {s1_y_r[CW-1], s1_y_r};
    ext_z = {s1_z_r[CW-1], s1_z_r};
    // Strict compares: ties fall to Y, then to Z
    if ((s1_ax_r > s1_ay_r) && (s1_ax_r > s1_az_r)) begin
      s2_ma_nxt = s1_ax_r;
      s2_t_nxt  = ext_y;
      if (s1_px_r) begin
        s2_face_nxt = cmfs_pkg::FACE_POS_X;
        s2_s_nxt    = ext_z;
      end else begin
        s2_face_nxt = cmfs_pkg::FACE_NEG_X;
        s2_s_nxt    = -ext_z;
      end
    end else if (s1_ay_r > s1_az_r) begin
      s2_ma_nxt = s1_ay_r;
      s2_s_nxt  = ext_x;
      if (s1_py_r) begin
        s2_face_nxt = cmfs_pkg::FACE_POS_Y;
        s2_t_nxt    = ext_z;
      end else begin
        s2_face_nxt = cmfs_pkg::FACE_NEG_Y;
        s2_t_nxt    = -ext_z;
      end
    end else begin
      s2_ma_nxt = s1_az_r;
      s2_t_nxt  = ext_y;
      if (s1_pz_r) begin
        s2_face_nxt = cmfs_pkg::FACE_POS_Z;
        s2_s_nxt    = -ext_x;
      end else begin
        s2_face_nxt = cmfs_pkg::FACE_NEG_Z;
        s2_s_nxt    = ext_x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_face_r <= s2_face_nxt;
    s2_ma_r   <= s2_ma_nxt;
    s2_s_r    <= s2_s_nxt;
    s2_t_r    <= s2_t_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: numerators s + ma, t + ma and denominator 2 * ma
  // ---------------------------------------------------------------------------
  cmfs_pkg::div_stage_t div_r [0:QW];
  logic [QW:0]          div_valid_r;

  // s + ma lies in [0, 2 * ma], so the low DW bits hold it exactly
  logic [DW-1:0]        sum_u, sum_v;
  logic [DW-1:0]        den_nxt;
  cmfs_pkg::div_stage_t div0_nxt;

  always_comb begin
    sum_u   = s2_s_r + {1'b0, s2_ma_r};
    sum_v   = s2_t_r + {1'b0, s2_ma_r};
    den_nxt = {s2_ma_r, 1'b0};
    div0_nxt.face   = s2_face_r;
    div0_nxt.zero   = (s2_ma_r == '0);
    div0_nxt.den    = den_nxt;
    div0_nxt.rem_u  = sum_u[DW-1:0];
    div0_nxt.rem_v  = sum_v[DW-1:0];
    div0_nxt.sat_u  = (sum_u[DW-1:0] == den_nxt);
    div0_nxt.sat_v  = (sum_v[DW-1:0] == den_nxt);
    div0_nxt.quot_u = '0;
    div0_nxt.quot_v = '0;
  end

  always_ff @(posedge clk) begin
    div_r[0] <= div0_nxt;
  end

  // ---------------------------------------------------------------------------
  // Divider: one restoring step per stage, MSB of the quotient first
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_valid_r <= '0;
    end else begin
      div_valid_r <= {div_valid_r[QW-1:0], s2_valid_r};
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [DW:0]          dbl_u, dbl_v;
    logic                 ge_u, ge_v;
    logic [DW:0]          sub_u, sub_v;
    cmfs_pkg::div_stage_t step_nxt;

    always_comb begin
      dbl_u = {div_r[k-1].rem_u, 1'b0};
      dbl_v = {div_r[k-1].rem_v, 1'b0};
      ge_u  = (dbl_u >= {1'b0, div_r[k-1].den});
      ge_v  = (dbl_v >= {1'b0, div_r[k-1].den});
      sub_u = dbl_u - {1'b0, div_r[k-1].den};
      sub_v = dbl_v - {1'b0, div_r[k-1].den};
      step_nxt        = div_r[k-1];
      step_nxt.rem_u  = ge_u ? sub_u[DW-1:0] : dbl_u[DW-1:0];
      step_nxt.rem_v  = ge_v ? sub_v[DW-1:0] : dbl_v[DW-1:0];
      step_nxt.quot_u = {div_r[k-1].quot_u[QW-2:0], ge_u};
      step_nxt.quot_v = {div_r[k-1].quot_v[QW-2:0], ge_v};
    end

    always_ff @(posedge clk) begin
      div_r[k] <= step_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: saturate 1.0, clear coordinates for a zero vector
  // ---------------------------------------------------------------------------
  logic [QW-1:0] coord_u_nxt, coord_v_nxt;

  always_comb begin
    if (div_r[QW].zero) begin
      coord_u_nxt = '0;
      coord_v_nxt = '0;
    end else begin
      coord_u_nxt = div_r[QW].sat_u ? '1 : div_r[QW].quot_u;
      coord_v_nxt = div_r[QW].sat_v ? '1 : div_r[QW].quot_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= div_valid_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    out_face        <= div_r[QW].face;
    out_coord_u     <= coord_u_nxt;
    out_coord_v     <= coord_v_nxt;
    out_zero_vector <= div_r[QW].zero;
  end

endmodule

@@ rtl/cmfs_checker.sv @@
`timescale 1ns / 1ps

module cmfs_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic signed [cmfs_pkg::COMP_WIDTH-1:0] in_dir_x,
  input logic signed [cmfs_pkg::COMP_WIDTH-1:0] in_dir_y,
  input logic signed [cmfs_pkg::COMP_WIDTH-1:0] in_dir_z,
  input logic                                 out_valid,
  input logic [2:0]                           out_face,
  input logic [cmfs_pkg::COORD_WIDTH-1:0]     out_coord_u,
  input logic [cmfs_pkg::COORD_WIDTH-1:0]     out_coord_v,
  input logic                                 out_zero_vector
);

  // Every accepted request yields a result
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(cmfs_pkg::LATENCY) out_valid)
    else $error("accepted request produced no result");

  // No result appears without a matching request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##(cmfs_pkg::LATENCY) !out_valid)
    else $error("result without request");

  // A zero direction is flagged at the output
  a_zero_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_dir_x == '0 && in_dir_y == '0 && in_dir_z == '0)
      |-> ##(cmfs_pkg::LATENCY) out_zero_vector)
    else $error("zero vector not flagged");

  // A flagged zero vector reports face -Z with cleared coordinates
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_vector) |->
      (out_face == cmfs_pkg::FACE_NEG_Z && out_coord_u == '0 && out_coord_v == '0))
    else $error("zero vector result malformed");

endmodule

bind cube_map_face_select cmfs_checker u_cmfs_checker (.*);

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT = 2000;
  localparam int RAND_PER_PHASE = 182;

  typedef logic signed [cmfs_pkg::COMP_WIDTH-1:0] comp_t;

  typedef struct {
    comp_t x;
    comp_t y;
    comp_t z;
  } dir_req_t;

  typedef struct {
    logic [2:0]                       face;
    logic [cmfs_pkg::COORD_WIDTH-1:0] u;
    logic [cmfs_pkg::COORD_WIDTH-1:0] v;
    logic                             zero;
  } face_result_t;

  logic                             clk;
  logic                             rst_n;
  logic                             start;
  logic                             busy;
  comp_t                            in_dir_x;
  comp_t                            in_dir_y;
  comp_t                            in_dir_z;
  logic                             out_valid;
  logic [2:0]                       out_face;
  logic [cmfs_pkg::COORD_WIDTH-1:0] out_coord_u;
  logic [cmfs_pkg::COORD_WIDTH-1:0] out_coord_v;
  logic                             out_zero_vector;

  dir_req_t     pending_dirs[$];
  face_result_t expected_faces[$];
  int           idle_pct = 0;
  int           dirs_queued = 0;
  int           dirs_taken = 0;
  int           fail_count = 0;
  int           quiet_cycles = 0;
  bit           req_fire = 1'b0;

  cube_map_face_select dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_dir_x       (in_dir_x),
    .in_dir_y       (in_dir_y),
    .in_dir_z       (in_dir_z),
    .out_valid      (out_valid),
    .out_face       (out_face),
    .out_coord_u    (out_coord_u),
    .out_coord_v    (out_coord_v),
    .out_zero_vector(out_zero_vector)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // floor((c + ma) * 2^COORD_WIDTH / (2 * ma)), clamped to all ones
  function automatic logic [cmfs_pkg::COORD_WIDTH-1:0] coord_fraction(longint c, longint ma);
    longint q;
    longint top;
    top = (longint'(1) <<< cmfs_pkg::COORD_WIDTH) - 1;
    q = ((c + ma) <<< cmfs_pkg::COORD_WIDTH) / (2 * ma);
    if (q > top) q = top;
    return q[cmfs_pkg::COORD_WIDTH-1:0];
  endfunction

  // Pick the major axis with strict compares, then map (s, t) onto the face
  function automatic face_result_t project_dir(dir_req_t d);
    face_result_t r;
    longint x, y, z, ax, ay, az, ma, s, t;
    x = longint'(d.x);
    y = longint'(d.y);
    z = longint'(d.z);
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    if (ax > ay && ax > az) begin
      ma = ax;
      if (x > 0) begin
        r.face = cmfs_pkg::FACE_POS_X; s = z;  t = y;
      end else begin
        r.face = cmfs_pkg::FACE_NEG_X; s = -z; t = y;
      end
    end else if (ay > az) begin
      ma = ay;
      if (y > 0) begin
        r.face = cmfs_pkg::FACE_POS_Y; s = x; t = z;
      end else begin
        r.face = cmfs_pkg::FACE_NEG_Y; s = x; t = -z;
      end
    end else begin
      ma = az;
      if (z > 0) begin
        r.face = cmfs_pkg::FACE_POS_Z; s = -x; t = y;
      end else begin
        r.face = cmfs_pkg::FACE_NEG_Z; s = x;  t = y;
      end
    end
    r.zero = (ma == 0);
    if (r.zero) begin
      r.u = '0;
      r.v = '0;
    end else begin
      r.u = coord_fraction(s, ma);
      r.v = coord_fraction(t, ma);
    end
    return r;
  endfunction

  function automatic comp_t extreme_comp();
    case ($urandom_range(5))
      0:       return {1'b1, {(cmfs_pkg::COMP_WIDTH-1){1'b0}}};
      1:       return {1'b0, {(cmfs_pkg::COMP_WIDTH-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      4:       return comp_t'(1);
      default: return {1'b1, {(cmfs_pkg::COMP_WIDTH-2){1'b0}}, 1'b1};
    endcase
  endfunction

  // Mostly full-range vectors, plus small, tied, extreme and zero vectors
  function automatic dir_req_t random_dir();
    dir_req_t d;
    comp_t m;
    int kind;
    kind = $urandom_range(19);
    m = comp_t'($urandom);
    d.x = comp_t'($urandom);
    d.y = comp_t'($urandom);
    d.z = comp_t'($urandom);
    if (kind >= 12 && kind <= 14) begin
      d.x = comp_t'(int'($urandom_range(8)) - 4);
      d.y = comp_t'(int'($urandom_range(8)) - 4);
      d.z = comp_t'(int'($urandom_range(8)) - 4);
    end else if (kind >= 15 && kind <= 17) begin
      // equal magnitudes on two or three axes
      case ($urandom_range(3))
        0: begin d.x = m; d.y = $urandom_range(1) ? m : -m; end
        1: begin d.x = m; d.z = $urandom_range(1) ? m : -m; end
        2: begin d.y = m; d.z = $urandom_range(1) ? m : -m; end
        default: begin
          d.x = m;
          d.y = $urandom_range(1) ? m : -m;
          d.z = $urandom_range(1) ? m : -m;
        end
      endcase
    end else if (kind == 18) begin
      d.x = extreme_comp();
      d.y = extreme_comp();
      d.z = extreme_comp();
    end else if (kind == 19) begin
      d.x = '0;
      d.y = '0;
      d.z = '0;
    end
    return d;
  endfunction

  task automatic push_dir(int x, int y, int z);
    dir_req_t d;
    d.x = comp_t'(x);
    d.y = comp_t'(y);
    d.z = comp_t'(z);
    pending_dirs.insert(pending_dirs.size(), d);
    dirs_queued++;
  endtask

  task automatic check_field(string name, int want, int got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Drive a new request once the previous one is taken, with random gaps
  always @(negedge clk) begin : drive_requests
    dir_req_t d;
    if (!rst_n) begin
      start    <= 1'b0;
      in_dir_x <= '0;
      in_dir_y <= '0;
      in_dir_z <= '0;
    end else if (!start || req_fire) begin
      if (pending_dirs.size() != 0 && int'($urandom_range(99)) >= idle_pct) begin
        d = pending_dirs.pop_front();
        in_dir_x <= d.x;
        in_dir_y <= d.y;
        in_dir_z <= d.z;
        start    <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Record accepted requests, check results, watch for a hang
  always @(posedge clk) begin : watch_ports
    dir_req_t     d;
    face_result_t want;
    req_fire = rst_n && start && !busy;
    if (req_fire) begin
      d.x = in_dir_x;
      d.y = in_dir_y;
      d.z = in_dir_z;
      expected_faces.insert(expected_faces.size(), project_dir(d));
      dirs_taken++;
    end
    if (rst_n && out_valid) begin
      if (expected_faces.size() == 0) begin
        fail_count++;
        $display("%0t: result with no request pending, expected none, actual face %0d",
                 $time, out_face);
      end else begin
        want = expected_faces.pop_front();
        check_field("face", int'(want.face), int'(out_face));
        check_field("coord_u", int'(want.u), int'(out_coord_u));
        check_field("coord_v", int'(want.v), int'(out_coord_v));
        check_field("zero_vector", int'(want.zero), int'(out_zero_vector));
      end
    end
    if (req_fire || (rst_n && out_valid)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Reset, directed vectors, then random phases at several sender gap rates
  initial begin : stimulus
    int gap_by_phase[4];
    gap_by_phase = '{0, 60, 0, 29};
    rst_n = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // zero vector and the six faces at full scale
    push_dir(0, 0, 0);
    push_dir(32767, 0, 0);
    push_dir(-32768, 0, 0);
    push_dir(0, 32767, 0);
    push_dir(0, -32768, 0);
    push_dir(0, 0, 32767);
    push_dir(0, 0, -32768);
    // ties fall to Y, then Z
    push_dir(100, 100, 5);
    push_dir(100, 5, 100);
    push_dir(5, -100, 100);
    push_dir(32767, 32767, 32767);
    push_dir(-32768, -32768, -32768);
    // exact 1.0 clamps to all ones
    push_dir(-50, 0, 50);
    push_dir(70, 70, 3);
    push_dir(50, 50, -50);
    // most negative component against near-max ones
    push_dir(-32768, 32767, 32767);
    push_dir(32767, -32768, -32767);
    push_dir(-32767, 32767, -32768);
    // unit-size vectors
    push_dir(1, 0, 0);
    push_dir(0, 0, -1);
    push_dir(1, -1, 1);
    push_dir(-1, 1, 0);

    foreach (gap_by_phase[p]) begin
      @(posedge clk);
      idle_pct = gap_by_phase[p];
      repeat (RAND_PER_PHASE) begin
        pending_dirs.insert(pending_dirs.size(), random_dir());
        dirs_queued++;
      end
      // hold the sender until every result of the phase is back
      do @(negedge clk); while (dirs_taken != dirs_queued || expected_faces.size() != 0);
    end

    // let any stray result show up before closing
    repeat (cmfs_pkg::LATENCY + 8) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/cmfs_pkg.sv
rtl/cube_map_face_select.sv
rtl/cmfs_checker.sv
bench/tb.sv
